FILE: sv/next_fit_free_list_allocator_top_assert.svh
// assertion macros for the allocator top level
`ifndef NEXT_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define NEXT_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define NFFA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define NFFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define NFFA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NFFA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/nffa_pkg.sv
`timescale 1ns / 1ps
package nffa_pkg;
   localparam int ARENA_UNITS = 4096;
   localparam int UNIT_BYTES = 16;
   localparam int PAGE_BYTES = 4096;
   localparam int ADDR_W = $clog2(ARENA_UNITS);
   localparam int NODE_W = ADDR_W + 1;
   localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
   localparam int SIZE_BYTES_W = 17;
   localparam int REQ_W = 12;

   localparam logic [NODE_W-1:0] SENT = NODE_W'(ARENA_UNITS);
   localparam logic [NODE_W-1:0] WALK_LIMIT = NODE_W'(ARENA_UNITS + 2);
   localparam logic [REQ_W-1:0] BIG_BYTES = REQ_W'(PAGE_BYTES - UNIT_BYTES);
   localparam logic [NODE_W-1:0] ROUND_ADD = NODE_W'(2 * UNIT_BYTES - 1);

   typedef enum logic [1:0] {
      OP_ALLOC, OP_FREE, OP_ADD_REGION, OP_QUERY
   } op_type;

   typedef enum logic [1:0] {
      ST_OK, ST_NO_SPACE, ST_TOO_LARGE
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_A_ROVER, S_A_FIRST, S_A_WALK, S_A_SPLIT, S_I_HDR, S_I_START,
      S_I_WALK, S_I_RDB, S_I_RDN, S_I_LINK, S_Q_RD, S_Q_DATA, S_RESP
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_LOAD, CMD_A_ROVER, CMD_A_FIRST, CMD_A_WALK, CMD_A_SPLIT,
      CMD_I_HDR, CMD_I_START, CMD_I_WALK, CMD_I_RDB, CMD_I_RDN, CMD_I_LINK,
      CMD_Q_RD, CMD_Q_DATA, CMD_RESP
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   too_large;
      logic   addr_zero;
      logic   runits_zero;
      logic   fit;
      logic   exact;
      logic   a_stop;
      logic   i_brk;
      logic   i_stop;
      logic   resp_free;
   } dp_stat_type;
endpackage

FILE: sv/nffa_if.sv
`timescale 1ns / 1ps
interface nffa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [11:0] request_bytes;
   logic [11:0] address;
   logic [11:0] region_units;
   modport source (output valid, operation, request_bytes, address, region_units,
                   input ready);
   modport sink (input valid, operation, request_bytes, address, region_units,
                 output ready);
endinterface

interface nffa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [11:0] result_address;
   logic [16:0] size_bytes;
   modport source (output valid, status, result_address, size_bytes, input ready);
   modport sink (input valid, status, result_address, size_bytes, output ready);
endinterface

FILE: sv/next_fit_free_list_allocator_top.sv
// one item at a time; the next item is taken once the result is loaded
// alloc: walks the nodes from the rover, plus a split step when the block is split
// free / add_region: walk from the rover to the break, then merge and link (add_region first writes the header)
// query: reads the block header; null or ignored requests go straight to the result; a waiting result stalls
// reset: synchronous, empties the list (rover and sentinel link); no memory clear
`timescale 1ns / 1ps
module next_fit_free_list_allocator_top (
   input  logic        clock,
   input  logic        reset,
   nffa_req_if.sink    req_ch,
   nffa_rsp_if.source  rsp_ch
);
   import nffa_pkg::*;

`include "next_fit_free_list_allocator_top_assert.svh"

   ctl_cmd_type ctl;
   dp_stat_type stat;

   nffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   nffa_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_ch.operation),
      .req_request_bytes (req_ch.request_bytes),
      .req_address       (req_ch.address),
      .req_region_units  (req_ch.region_units),
      .ctl               (ctl),
      .stat              (stat),
      .rsp_ch            (rsp_ch)
   );

   `NFFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `NFFA_ASSERT_IMP(a_status_code, clock, reset, rsp_ch.valid, rsp_ch.status != 2'd3)
   `NFFA_ASSERT_IMP(a_fail_no_data, clock, reset, rsp_ch.valid && (rsp_ch.status != ST_OK), (rsp_ch.result_address == '0) && (rsp_ch.size_bytes == '0))
endmodule

FILE: sv/nffa_ram.sv
`timescale 1ns / 1ps
module nffa_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: sv/nffa_ctrl.sv
`timescale 1ns / 1ps
module nffa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  nffa_pkg::dp_stat_type stat,
   output nffa_pkg::ctl_cmd_type ctl
);
   import nffa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (stat.op)
                  OP_ALLOC: state_in = stat.too_large ? S_RESP : S_A_ROVER;
                  OP_FREE: state_in = stat.addr_zero ? S_RESP : S_I_START;
                  OP_ADD_REGION: state_in = stat.runits_zero ? S_RESP : S_I_HDR;
                  OP_QUERY: state_in = stat.addr_zero ? S_RESP : S_Q_RD;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_A_ROVER: state_in = S_A_FIRST;
         S_A_FIRST: state_in = S_A_WALK;
         S_A_WALK: begin
            if (stat.fit) begin
               state_in = stat.exact ? S_RESP : S_A_SPLIT;
            end else if (stat.a_stop) begin
               state_in = S_RESP;
            end
         end
         S_A_SPLIT: state_in = S_RESP;
         S_I_HDR: state_in = S_I_START;
         S_I_START: state_in = S_I_WALK;
         S_I_WALK: begin
            if (stat.i_brk) begin
               state_in = S_I_RDB;
            end else if (stat.i_stop) begin
               state_in = S_RESP;
            end
         end
         S_I_RDB: state_in = S_I_RDN;
         S_I_RDN: state_in = S_I_LINK;
         S_I_LINK: state_in = S_RESP;
         S_Q_RD: state_in = S_Q_DATA;
         S_Q_DATA: state_in = S_RESP;
         S_RESP: begin
            if (stat.resp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctl.cmd = CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            ctl.cmd = req_valid ? CMD_LOAD : CMD_NONE;
         end
         S_A_ROVER: ctl.cmd = CMD_A_ROVER;
         S_A_FIRST: ctl.cmd = CMD_A_FIRST;
         S_A_WALK: ctl.cmd = CMD_A_WALK;
         S_A_SPLIT: ctl.cmd = CMD_A_SPLIT;
         S_I_HDR: ctl.cmd = CMD_I_HDR;
         S_I_START: ctl.cmd = CMD_I_START;
         S_I_WALK: ctl.cmd = CMD_I_WALK;
         S_I_RDB: ctl.cmd = CMD_I_RDB;
         S_I_RDN: ctl.cmd = CMD_I_RDN;
         S_I_LINK: ctl.cmd = CMD_I_LINK;
         S_Q_RD: ctl.cmd = CMD_Q_RD;
         S_Q_DATA: ctl.cmd = CMD_Q_DATA;
         S_RESP: ctl.cmd = CMD_RESP;
         default: ctl.cmd = CMD_NONE;
      endcase
   end
endmodule

FILE: sv/nffa_dp.sv
`timescale 1ns / 1ps
module nffa_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_operation,
   input  logic [11:0]           req_request_bytes,
   input  logic [11:0]           req_address,
   input  logic [11:0]           req_region_units,
   input  nffa_pkg::ctl_cmd_type ctl,
   output nffa_pkg::dp_stat_type stat,
   nffa_rsp_if.source            rsp_ch
);
   import nffa_pkg::*;

   logic [NODE_W-1:0] rover_ff, rover_in, sent_next_ff, sent_next_in;
   logic [NODE_W-1:0] prev_ff, prev_in, cur_ff, cur_in, nx_ff, nx_in;
   logic [NODE_W-1:0] steps_ff, steps_in, cur_size_ff, cur_size_in;
   logic [NODE_W-1:0] bs_ff, bs_in, after_ff, after_in;
   logic [NODE_W-1:0] new_bs_ff, new_bs_in, new_bnext_ff, new_bnext_in;
   logic [NODE_W-1:0] units_ff, units_in, len_ff, len_in;
   logic [ADDR_W-1:0] b_ff, b_in;
   logic [NODE_W-1:0] rd_node_ff, rd_node_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [SIZE_BYTES_W-1:0] res_size_ff, res_size_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [SIZE_BYTES_W-1:0] rsp_size_ff, rsp_size_in;

   logic              s_we, n_we;
   logic [NODE_W-1:0] s_wa, s_wd, n_wa, n_wd;
   logic [NODE_W-1:0] size_q, next_q, node_size, node_next;
   logic [NODE_W-1:0] b13, tail, room, runits13;
   logic              fit, exact, a_stop, brk, i_stop, resp_free, mnext, mprev;
   logic [NODE_W:0]   b_end, cur_end;

   nffa_ram #(.WIDTH(NODE_W), .DEPTH(ARENA_UNITS)) u_size_ram (
      .clock (clock),
      .we    (s_we && !s_wa[NODE_W-1]),
      .waddr (s_wa[ADDR_W-1:0]),
      .wdata (s_wd),
      .raddr (rd_node_in[ADDR_W-1:0]),
      .rdata (size_q)
   );

   nffa_ram #(.WIDTH(NODE_W), .DEPTH(ARENA_UNITS)) u_next_ram (
      .clock (clock),
      .we    (n_we && !n_wa[NODE_W-1]),
      .waddr (n_wa[ADDR_W-1:0]),
      .wdata (n_wd),
      .raddr (rd_node_in[ADDR_W-1:0]),
      .rdata (next_q)
   );

   // the sentinel and codes above the arena do not live in the memory
   assign node_size = rd_node_ff[NODE_W-1] ? '0 : size_q;
   assign node_next = rd_node_ff[NODE_W-1] ? ((rd_node_ff == SENT) ? sent_next_ff : '0)
                                           : next_q;

   assign b13 = {1'b0, b_ff};
   assign tail = cur_ff + units_ff;
   assign room = SENT - {1'b0, req_address};
   assign runits13 = {1'b0, req_region_units};
   assign fit = (cur_ff != SENT) && (node_size >= units_ff);
   assign exact = node_size == units_ff;
   assign a_stop = !fit && ((cur_ff == rover_ff) || (steps_ff >= WALK_LIMIT));
   assign brk = ((b13 > cur_ff) && (b13 < node_next))
             || ((cur_ff >= node_next) && ((b13 > cur_ff) || (b13 < node_next)));
   assign i_stop = !brk && (steps_ff >= WALK_LIMIT);
   assign b_end = {1'b0, b13} + {1'b0, bs_ff};
   assign cur_end = {1'b0, cur_ff} + {1'b0, cur_size_ff};
   assign mnext = (nx_ff != SENT) && (b_end == {1'b0, nx_ff});
   assign mprev = (cur_ff != SENT) && (cur_end == {1'b0, b13});
   assign resp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      stat.op = op_type'(req_operation);
      stat.too_large = req_request_bytes >= BIG_BYTES;
      stat.addr_zero = req_address == '0;
      stat.runits_zero = req_region_units == '0;
      stat.fit = fit;
      stat.exact = exact;
      stat.a_stop = a_stop;
      stat.i_brk = brk;
      stat.i_stop = i_stop;
      stat.resp_free = resp_free;
   end

   always_comb begin
      rover_in = rover_ff;
      sent_next_in = sent_next_ff;
      prev_in = prev_ff;
      cur_in = cur_ff;
      nx_in = nx_ff;
      steps_in = steps_ff;
      cur_size_in = cur_size_ff;
      bs_in = bs_ff;
      after_in = after_ff;
      new_bs_in = new_bs_ff;
      new_bnext_in = new_bnext_ff;
      units_in = units_ff;
      len_in = len_ff;
      b_in = b_ff;
      rd_node_in = rd_node_ff;
      res_status_in = res_status_ff;
      res_addr_in = res_addr_ff;
      res_size_in = res_size_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_size_in = rsp_size_ff;
      s_we = 1'b0;
      s_wa = '0;
      s_wd = '0;
      n_we = 1'b0;
      n_wa = '0;
      n_wd = '0;

      unique case (ctl.cmd)
         CMD_LOAD: begin
            units_in = NODE_W'(({1'b0, req_request_bytes} + ROUND_ADD) >> UNIT_SHIFT);
            // free and query carry the payload index, the header sits one unit below
            b_in = (op_type'(req_operation) inside {OP_FREE, OP_QUERY})
                 ? req_address - 1'b1 : req_address;
            len_in = (runits13 > room) ? room : runits13;
            res_status_in = ((op_type'(req_operation) == OP_ALLOC) && stat.too_large)
                          ? ST_TOO_LARGE : ST_OK;
            res_addr_in = '0;
            res_size_in = '0;
         end
         CMD_A_ROVER: rd_node_in = rover_ff;
         CMD_A_FIRST: begin
            prev_in = rover_ff;
            cur_in = node_next;
            rd_node_in = node_next;
            steps_in = '0;
         end
         CMD_A_WALK: begin
            if (fit) begin
               n_we = 1'b1;
               n_wa = prev_ff;
               if (exact) begin
                  n_wd = node_next;
                  rover_in = prev_ff;
                  res_addr_in = cur_ff[ADDR_W-1:0] + 1'b1;
               end else begin
                  n_wd = tail;
                  s_we = 1'b1;
                  s_wa = tail;
                  s_wd = node_size - units_ff;
                  after_in = node_next;
               end
               if (prev_ff == SENT) begin
                  sent_next_in = n_wd;
               end
            end else if (a_stop) begin
               res_status_in = ST_NO_SPACE;
            end else begin
               prev_in = cur_ff;
               cur_in = node_next;
               rd_node_in = node_next;
               steps_in = steps_ff + 1'b1;
            end
         end
         CMD_A_SPLIT: begin
            n_we = 1'b1;
            n_wa = tail;
            n_wd = after_ff;
            if (tail == SENT) begin
               sent_next_in = after_ff;
            end
            s_we = 1'b1;
            s_wa = cur_ff;
            s_wd = units_ff;
            rover_in = prev_ff;
            res_addr_in = cur_ff[ADDR_W-1:0] + 1'b1;
         end
         CMD_I_HDR: begin
            s_we = 1'b1;
            s_wa = b13;
            s_wd = len_ff;
         end
         CMD_I_START: begin
            rd_node_in = rover_ff;
            cur_in = rover_ff;
            steps_in = '0;
         end
         CMD_I_WALK: begin
            if (brk) begin
               cur_size_in = node_size;
               nx_in = node_next;
               rd_node_in = b13;
            end else if (i_stop) begin
               res_status_in = ST_NO_SPACE;
            end else begin
               cur_in = node_next;
               rd_node_in = node_next;
               steps_in = steps_ff + 1'b1;
            end
         end
         CMD_I_RDB: begin
            bs_in = node_size;
            rd_node_in = nx_ff;
         end
         CMD_I_RDN: begin
            n_we = 1'b1;
            n_wa = b13;
            if (mnext) begin
               s_we = 1'b1;
               s_wa = b13;
               s_wd = bs_ff + node_size;
               n_wd = node_next;
               new_bs_in = bs_ff + node_size;
               new_bnext_in = node_next;
            end else begin
               n_wd = nx_ff;
               new_bs_in = bs_ff;
               new_bnext_in = nx_ff;
            end
         end
         CMD_I_LINK: begin
            n_we = 1'b1;
            n_wa = cur_ff;
            if (mprev) begin
               s_we = 1'b1;
               s_wa = cur_ff;
               s_wd = cur_size_ff + new_bs_ff;
               n_wd = new_bnext_ff;
            end else begin
               n_wd = b13;
            end
            if (cur_ff == SENT) begin
               sent_next_in = n_wd;
            end
            rover_in = cur_ff;
         end
         CMD_Q_RD: rd_node_in = b13;
         CMD_Q_DATA: res_size_in = SIZE_BYTES_W'({node_size, {UNIT_SHIFT{1'b0}}});
         CMD_RESP: begin
            if (resp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in = res_addr_ff;
               rsp_size_in = res_size_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rover_ff <= SENT;
         sent_next_ff <= SENT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rover_ff <= rover_in;
         sent_next_ff <= sent_next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      cur_ff <= cur_in;
      nx_ff <= nx_in;
      steps_ff <= steps_in;
      cur_size_ff <= cur_size_in;
      bs_ff <= bs_in;
      after_ff <= after_in;
      new_bs_ff <= new_bs_in;
      new_bnext_ff <= new_bnext_in;
      units_ff <= units_in;
      len_ff <= len_in;
      b_ff <= b_in;
      rd_node_ff <= rd_node_in;
      res_status_ff <= res_status_in;
      res_addr_ff <= res_addr_in;
      res_size_ff <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_size_ff <= rsp_size_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.result_address = rsp_addr_ff;
   assign rsp_ch.size_bytes = rsp_size_ff;
endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import nffa_pkg::*;

   typedef struct {
      op_type      op;
      logic [11:0] bytes;
      logic [11:0] addr;
      logic [11:0] units;
   } alloc_req_type;

   typedef struct {
      status_type  status;
      logic [11:0] addr;
      logic [16:0] size;
   } alloc_rsp_type;

   // directed row: pick 1 = latest grant, 2 = grant before it
   typedef struct {
      op_type      op;
      int          bytes;
      int          addr;
      int          units;
      int          pick;
      bit          typed;
      status_type  status;
      int          raddr;
      int          rsize;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nffa_req_if req ();
   nffa_rsp_if rsp ();

   next_fit_free_list_allocator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp)
   );

   always #2 clock = ~clock;

   // shadow of the free list
   logic [12:0] hdr_size [ARENA_UNITS];
   logic [12:0] hdr_next [ARENA_UNITS];
   logic [12:0] rover_q;
   logic [12:0] head_q;

   alloc_rsp_type pending_rsp[$];
   logic [11:0] live_blocks[$];
   logic [11:0] ever_blocks[$];
   int errors = 0;
   int n_sent = 0, n_got = 0;
   int n_op[4] = '{0, 0, 0, 0};
   int n_st[3] = '{0, 0, 0};

   function automatic int size_of(int i);
      return (i < ARENA_UNITS) ? int'(hdr_size[i]) : 0;
   endfunction

   function automatic int next_of(int i);
      if (i == ARENA_UNITS) return int'(head_q);
      return (i < ARENA_UNITS) ? int'(hdr_next[i]) : 0;
   endfunction

   function automatic void put_size(int i, int v);
      if (i < ARENA_UNITS) hdr_size[i] = 13'(v);
   endfunction

   function automatic void put_next(int i, int v);
      if (i == ARENA_UNITS) head_q = 13'(v);
      else if (i < ARENA_UNITS) hdr_next[i] = 13'(v);
   endfunction

   function automatic bit link_block(int b);
      int cur, nx, steps, bs;
      cur = int'(rover_q);
      steps = 0;
      forever begin
         nx = next_of(cur);
         if (b > cur && b < nx) break;
         if (cur >= nx && (b > cur || b < nx)) break;
         cur = nx;
         steps++;
         if (steps > ARENA_UNITS + 2) return 1'b0;
      end
      bs = size_of(b);
      if (nx != ARENA_UNITS && b + bs == nx) begin
         put_size(b, bs + size_of(nx));
         put_next(b, next_of(nx));
      end else begin
         put_next(b, nx);
      end
      if (cur != ARENA_UNITS && cur + size_of(cur) == b) begin
         put_size(cur, size_of(cur) + size_of(b));
         put_next(cur, next_of(b));
      end else begin
         put_next(cur, b);
      end
      rover_q = 13'(cur);
      return 1'b1;
   endfunction

   function automatic status_type grant(int bytes, output logic [11:0] got);
      int units, prev, cur, sz, steps, tail, after;
      got = '0;
      if (bytes >= PAGE_BYTES - UNIT_BYTES) return ST_TOO_LARGE;
      units = (bytes + 2 * UNIT_BYTES - 1) / UNIT_BYTES;
      prev = int'(rover_q);
      cur = next_of(prev);
      steps = 0;
      forever begin
         sz = size_of(cur);
         if (cur != ARENA_UNITS && sz >= units) begin
            if (sz == units) begin
               put_next(prev, next_of(cur));
            end else begin
               tail = cur + units;
               after = next_of(cur);
               put_next(prev, tail);
               put_size(tail, sz - units);
               put_next(tail, after);
               put_size(cur, units);
            end
            rover_q = 13'(prev);
            got = 12'(cur + 1);
            return ST_OK;
         end
         if (cur == int'(rover_q)) return ST_NO_SPACE;
         prev = cur;
         cur = next_of(cur);
         steps++;
         if (steps > ARENA_UNITS + 2) return ST_NO_SPACE;
      end
   endfunction

   function automatic alloc_rsp_type predict_rsp(alloc_req_type r);
      alloc_rsp_type e;
      int a, len;
      e.status = ST_OK;
      e.addr = '0;
      e.size = '0;
      a = int'(r.addr);
      case (r.op)
         OP_ALLOC: begin
            e.status = grant(int'(r.bytes), e.addr);
         end
         OP_FREE: begin
            if (a != 0 && !link_block(a - 1)) e.status = ST_NO_SPACE;
         end
         OP_ADD_REGION: begin
            if (r.units != 0) begin
               len = int'(r.units);
               if (len > ARENA_UNITS - a) len = ARENA_UNITS - a;
               put_size(a, len);
               if (!link_block(a)) e.status = ST_NO_SPACE;
            end
         end
         default: begin
            if (a != 0) e.size = 17'(size_of(a - 1) * UNIT_BYTES);
         end
      endcase
      return e;
   endfunction

   // sender burst state
   int burst_left = 0;

   task automatic send_item(alloc_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req.valid = 1'b0;
            req.operation = 2'($urandom);
            req.request_bytes = 12'($urandom);
            req.address = 12'($urandom);
            req.region_units = 12'($urandom);
         end
      end
      burst_left--;
      @(negedge clock);
      req.valid = 1'b1;
      req.operation = r.op;
      req.request_bytes = r.bytes;
      req.address = r.addr;
      req.region_units = r.units;
      do @(posedge clock); while (!req.ready);
      n_sent++;
      n_op[r.op]++;
   endtask

   function automatic void forget_block(logic [11:0] a);
      foreach (live_blocks[i]) begin
         if (live_blocks[i] == a) begin
            live_blocks.delete(i);
            return;
         end
      end
   endfunction

   function automatic void note_grant(alloc_req_type r, alloc_rsp_type e);
      if (r.op == OP_ALLOC && e.status == ST_OK && e.addr != 0) begin
         live_blocks.push_back(e.addr);
         ever_blocks.push_back(e.addr);
      end
      if (r.op == OP_FREE) forget_block(r.addr);
   endfunction

   // receiver stall pattern: rotates through always ready, mostly ready and mostly stalled
   int rx_cycle = 0;
   always @(negedge clock) begin
      int mode;
      mode = (rx_cycle / 150) % 3;
      rx_cycle++;
      case (mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= ($urandom_range(0, 3) != 0);
         default: rsp.ready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   always @(posedge clock) begin
      alloc_rsp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         n_got++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected item status=%0d addr=%0d size=%0d", $time,
                     rsp.status, rsp.result_address, rsp.size_bytes);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp.status < 3) n_st[rsp.status]++;
            if (rsp.status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status,
                        rsp.status);
               errors++;
            end
            if (rsp.result_address !== e.addr) begin
               $display("%0t: result_address expected %0d actual %0d", $time,
                        e.addr, rsp.result_address);
               errors++;
            end
            if (rsp.size_bytes !== e.size) begin
               $display("%0t: size_bytes expected %0d actual %0d", $time, e.size,
                        rsp.size_bytes);
               errors++;
            end
         end
      end
   end

   // a full-length walk on every item still ends far below this
   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      row_type rows[$];
      alloc_req_type r;
      alloc_rsp_type e, t;
      logic [11:0] latest, earlier;
      int cursor, len, pick, waited;

      rsp.ready = 1'b0;
      req.valid = 1'b0;
      req.operation = OP_ALLOC;
      req.request_bytes = '0;
      req.address = '0;
      req.region_units = '0;
      for (int i = 0; i < ARENA_UNITS; i++) begin
         hdr_size[i] = '0;
         hdr_next[i] = '0;
      end
      rover_q = SENT;
      head_q = SENT;
      latest = '0;
      earlier = '0;

      // op, bytes, addr, units, pick, typed, status, addr, size
      rows = '{
         '{OP_ALLOC, 100, 0, 0, 0, 1, ST_NO_SPACE, 0, 0},    // empty list
         '{OP_ALLOC, 4095, 0, 0, 0, 1, ST_TOO_LARGE, 0, 0},
         '{OP_ALLOC, 4080, 0, 0, 0, 1, ST_TOO_LARGE, 0, 0},
         '{OP_ADD_REGION, 0, 4095, 1, 0, 1, ST_OK, 0, 0},
         '{OP_ALLOC, 0, 0, 0, 0, 1, ST_OK, 0, 0},             // payload wraps
         '{OP_ADD_REGION, 0, 4090, 4095, 0, 1, ST_OK, 0, 0},  // clipped at end
         '{OP_ADD_REGION, 0, 100, 0, 0, 1, ST_OK, 0, 0},      // zero units
         '{OP_FREE, 0, 0, 0, 0, 1, ST_OK, 0, 0},
         '{OP_QUERY, 0, 0, 0, 0, 1, ST_OK, 0, 0},
         '{OP_ADD_REGION, 0, 0, 100, 0, 0, ST_OK, 0, 0},
         '{OP_ALLOC, 4079, 0, 0, 0, 0, ST_OK, 0, 0},
         '{OP_ALLOC, 64, 0, 0, 0, 0, ST_OK, 0, 0},            // 5 units, split from a larger free block
         '{OP_ALLOC, 16, 0, 0, 0, 0, ST_OK, 0, 0},
         '{OP_ALLOC, 32, 0, 0, 0, 0, ST_OK, 0, 0},
         '{OP_QUERY, 0, 0, 0, 1, 0, ST_OK, 0, 0},
         '{OP_FREE, 0, 0, 0, 2, 0, ST_OK, 0, 0},
         '{OP_FREE, 0, 0, 0, 2, 0, ST_OK, 0, 0},              // double free
         '{OP_FREE, 0, 0, 0, 1, 0, ST_OK, 0, 0},
         '{OP_QUERY, 0, 0, 0, 2, 0, ST_OK, 0, 0},
         '{OP_ALLOC, 2047, 0, 0, 0, 0, ST_OK, 0, 0}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         r.op = rows[i].op;
         r.bytes = 12'(rows[i].bytes);
         r.units = 12'(rows[i].units);
         case (rows[i].pick)
            1: r.addr = latest;
            2: r.addr = earlier;
            default: r.addr = 12'(rows[i].addr);
         endcase
         e = predict_rsp(r);
         if (rows[i].typed) begin
            t.status = rows[i].status;
            t.addr = 12'(rows[i].raddr);
            t.size = 17'(rows[i].rsize);
            pending_rsp.push_back(t);
         end else begin
            pending_rsp.push_back(e);
         end
         if (r.op == OP_ALLOC && e.status == ST_OK) begin
            earlier = latest;
            latest = e.addr;
         end
         send_item(r);
      end
      live_blocks.delete();

      cursor = 300;
      for (int n = 0; n < 500; n++) begin
         pick = $urandom_range(0, 99);
         r.bytes = '0;
         r.addr = '0;
         r.units = '0;
         if (pick < 15 && cursor < 3950) begin
            r.op = OP_ADD_REGION;
            len = $urandom_range(1, 40);
            if (cursor + len > 3990) len = 3990 - cursor;
            r.addr = 12'(cursor);
            r.units = 12'(len);
            // sometimes leave a hole, sometimes abut the previous region
            cursor += len + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4));
         end else if (pick < 55 || (pick < 85 && live_blocks.size() == 0)) begin
            r.op = OP_ALLOC;
            if ($urandom_range(0, 9) == 0) r.bytes = 12'($urandom);
            else r.bytes = 12'($urandom_range(0, 300));
         end else if (pick < 85) begin
            r.op = OP_FREE;
            r.addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
         end else if (pick < 90) begin
            r.op = ($urandom_range(0, 1) == 0) ? OP_FREE : OP_QUERY;
            r.units = 12'($urandom);
            r.bytes = 12'($urandom);
         end else begin
            r.op = OP_QUERY;
            if (ever_blocks.size() != 0)
               r.addr = ever_blocks[$urandom_range(0, ever_blocks.size() - 1)];
         end
         e = predict_rsp(r);
         pending_rsp.push_back(e);
         note_grant(r, e);
         send_item(r);
      end
      @(negedge clock);
      req.valid = 1'b0;

      waited = 0;
      while (pending_rsp.size() != 0) begin
         @(posedge clock);
         waited++;
         if (waited > 200_000) begin
            $display("tb: failure");
            $finish;
         end
      end
      repeat (100) @(posedge clock);

      $display("ran %0d items: %0d alloc, %0d free, %0d add_region, %0d query",
               n_sent, n_op[OP_ALLOC], n_op[OP_FREE], n_op[OP_ADD_REGION],
               n_op[OP_QUERY]);
      $display("results %0d: ok %0d, no_space %0d, too_large %0d, %0d errors",
               n_got, n_st[0], n_st[1], n_st[2], errors);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
